// ===== rtl/core/hls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hls_pkg;
	localparam int MAX_TERMS = 64;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int TNUM_W = 32 + CNT_W;
	localparam int DIV_W = 64;
	localparam int SUM_W = 40;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ZDIV = 8'b0000_0010,
		S_ZLD  = 8'b0000_0100,
		S_SQR  = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_SCL  = 8'b0010_0000,
		S_TDIV = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/half_log_series.sv =====
// for n terms (n saturated to MAX_TERMS) the sequencer divides for z, loads it and squares it,
// then per term multiplies by z^2, scales by 2i-1 and divides by 2i+1; n < 2 goes straight to S_FIN
// a new item is accepted only in S_IDLE, after the last result is loaded; a shared multiplier and a
// one-bit-per-cycle restoring divider do the work, with a small multiply by 2i-1 in S_SCL;
// the divide by 2i+1 sets the per-term cost
// a finished result waits in the output register while the next item is accepted
// reset: arst_n clears the sequencer and the output valid, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module half_log_series import hls_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] x_value,
	input  wire logic [6:0]  term_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] half_log,
	output logic             count_error
);
	state_t state_q;
	logic [CNT_W-1:0] n_q, i_q;
	logic [6:0] div_cnt_q;
	logic [DIV_W-1:0] num_q;
	logic [32:0] den_q, rem_q;
	logic [30:0] term_q, z2_q;
	logic [SUM_W-1:0] sum_q;
	logic neg_q, err_q;

	logic [33:0] rem_next;
	logic ge;
	logic [30:0] mul_b;
	logic [61:0] prod;
	logic [31:0] prod_rnd;
	logic [CNT_W:0] odd_f, den_f;
	logic [TNUM_W-1:0] tnum;
	logic [32:0] x_den, x_diff;
	logic [63:0] z_num;
	logic [31:0] zq;
	logic [30:0] zmag;
	logic [SUM_W-1:0] mag;
	logic [31:0] res;
	logic out_free;
	logic out_load;
	logic [7:0] n_in;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;
	assign out_load = (state_q == S_FIN) && (err_q || i_q == '0) && out_free;

	assign rem_next = {rem_q, num_q[DIV_W-1]};
	assign ge = rem_next >= {1'b0, den_q};

	assign mul_b = (state_q == S_SQR) ? term_q : z2_q;
	assign prod = 62'(term_q) * 62'(mul_b);
	assign prod_rnd = 32'((prod + 62'(1 << 29)) >> 30);

	assign odd_f = {i_q, 1'b0} - (CNT_W+1)'(1);
	assign den_f = {i_q, 1'b0} + (CNT_W+1)'(1);
	// rounding offset (2i+1)/2 is just i
	assign tnum = TNUM_W'(term_q) * TNUM_W'(odd_f) + TNUM_W'(i_q);

	assign x_den = {1'b0, x_value} + 33'd65536;
	assign x_diff = (x_value < 32'd65536) ? (33'd65536 - {1'b0, x_value})
		: ({1'b0, x_value} - 33'd65536);
	assign z_num = {x_diff[33-1:0], 30'd0} + 64'(x_den >> 1);

	assign zq = num_q[31:0];
	assign zmag = (zq > 32'h4000_0000) ? 31'h4000_0000 : zq[30:0];

	assign mag = (sum_q + SUM_W'(32)) >> 6;
	assign res = neg_q ? (32'd0 - mag[31:0]) : mag[31:0];
	assign n_in = {1'b0, term_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						neg_q <= x_value < 32'd65536;
						err_q <= term_count < 7'd2;
						n_q <= (n_in > 8'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(term_count);
						sum_q <= '0;
						num_q <= z_num;
						den_q <= x_den;
						rem_q <= '0;
						div_cnt_q <= 7'(DIV_W);
						state_q <= (term_count < 7'd2) ? S_FIN : S_ZDIV;
					end
				end
				S_ZDIV, S_TDIV: begin
					num_q <= {num_q[DIV_W-2:0], ge};
					rem_q <= ge ? 33'(rem_next - {1'b0, den_q}) : rem_next[32:0];
					div_cnt_q <= div_cnt_q - 7'd1;
					if (div_cnt_q == 7'd1)
						state_q <= (state_q == S_ZDIV) ? S_ZLD : S_FIN;
				end
				S_ZLD: begin
					term_q <= zmag;
					sum_q <= SUM_W'(zmag);
					i_q <= CNT_W'(1);
					state_q <= S_SQR;
				end
				S_SQR: begin
					z2_q <= prod_rnd[30:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					term_q <= prod_rnd[30:0];
					state_q <= S_SCL;
				end
				S_SCL: begin
					num_q <= {tnum, {(DIV_W-TNUM_W){1'b0}}};
					den_q <= 33'(den_f);
					rem_q <= '0;
					div_cnt_q <= 7'(TNUM_W);
					state_q <= S_TDIV;
				end
				S_FIN: begin
					// a term division just ended unless this is the count error path or the final result is waiting
					if (!err_q && i_q != '0) begin
						term_q <= num_q[30:0];
						sum_q <= sum_q + SUM_W'(num_q[30:0]);
						if (i_q == n_q) begin
							i_q <= '0;
						end else begin
							i_q <= i_q + CNT_W'(1);
							state_q <= S_MUL;
						end
					end else if (out_free) begin
						half_log <= err_q ? 32'sd0 : signed'(res);
						count_error <= err_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_error |-> half_log == 32'sd0)
		else $error("count error with nonzero result");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ZDIV || state_q == S_TDIV) |-> div_cnt_q != 7'd0)
		else $error("divider running with zero count");
	a_term_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_SCL || state_q == S_TDIV) |-> i_q <= n_q && i_q != '0)
		else $error("term index out of range");
	a_z_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> z2_q <= 31'h4000_0000)
		else $error("z squared above one");
endmodule
`default_nettype wire
